### hw/rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Shared types, codes and helpers for the timer queue cell chain.
// ----------------------------------------------------------------------------
package stq_pkg;

    // Default number of cells in the chain.
    localparam int STQ_NUM_SLOTS = 8;

    // Field widths.
    localparam int SLOT_W = 3;
    localparam int TIME_W = 16;
    localparam int CODE_W = 8;

    // Request operation codes.
    typedef enum logic [1:0] {
        OP_SCHEDULE = 2'd0,
        OP_CANCEL   = 2'd1,
        OP_TICK     = 2'd2
    } t_op;

    // Result kinds.
    localparam logic KIND_FIRED = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_LATE_LIMIT     = 1'b0;
    localparam logic CFG_TIMER_OVERHEAD = 1'b1;

    // One queue entry held by a cell.
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] deadline;
        logic [CODE_W-1:0] code;
    } t_entry;

    // Command broadcast to every cell.
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_REMOVE,
        CMD_INSERT,
        CMD_POP
    } t_cell_cmd;

    // Control bundle broadcast from the sequencer to the chain.
    typedef struct packed {
        t_cell_cmd         cmd;
        logic [SLOT_W-1:0] key;
        logic [TIME_W-1:0] now;
        t_entry            entry;
    } t_cell_ctl;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_CHECK,
        ST_CLOSE
    } t_state;

    // Wrapped distance of a deadline ahead of the current count.
    function automatic logic [TIME_W-1:0] t_dist(input logic [TIME_W-1:0] deadline,
                                                 input logic [TIME_W-1:0] now);
        t_dist = deadline - now;
    endfunction

endpackage

### hw/rtl/stq_cell.sv
// ----------------------------------------------------------------------------
// Sorted timer queue cell
// Holds one queue position and shifts entries to or from its neighbors.
// ----------------------------------------------------------------------------
module stq_cell
    import stq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_left,
    input  t_entry    i_right,
    input  logic      i_rm,
    input  logic      i_pass,
    output t_entry    o_entry,
    output logic      o_rm,
    output logic      o_pass
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_match;
    logic   w_less;

    // Local decisions: slot match for removal, earlier deadline for insertion.
    assign w_match = r_entry.valid && (r_entry.slot == i_ctl.key);
    assign w_less  = r_entry.valid &&
                     (t_dist(r_entry.deadline, i_ctl.now) < t_dist(i_ctl.entry.deadline, i_ctl.now));

    assign o_rm   = i_rm | w_match;
    assign o_pass = i_pass & w_less;

    // Next entry from the broadcast command and the chain signals.
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.cmd)
            CMD_REMOVE: begin
                if (i_rm || w_match) begin
                    n_entry = i_right;
                end
            end
            CMD_INSERT: begin
                if (!i_pass) begin
                    n_entry = i_left;
                end else if (!w_less) begin
                    n_entry = i_ctl.entry;
                end
            end
            CMD_POP: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // Entry register; only the valid bit is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

### hw/rtl/sorted_software_timer_queue_top.sv
// ----------------------------------------------------------------------------
// Sorted timer queue top level
// Keeps timer slots ordered by deadline in a chain of cells and reports
// expired timers followed by the compare status.
// ----------------------------------------------------------------------------
// Each request is taken in the idle state and then handled one step per
// cycle while the output does not stall, by a row of NUM_SLOTS cells: one
// step to remove the slot (schedule and cancel), one to insert it (schedule
// only), one per fired timer popped off the head, one to decide that the
// head has not expired and one to load the closing status.
// Results pass through an output register so a stall holds the sequencer only.
module sorted_software_timer_queue_top
    import stq_pkg::*;
#(
    parameter int NUM_SLOTS = STQ_NUM_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // slot[2:0], when[18:3], what[26:19], now[42:27]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // fired_slot[2:0], fired_code[10:3],
                                        // fired_deadline[26:11], compare_value[42:27],
                                        // compare_enable[43]
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last
);

    // Configuration registers.
    logic [TIME_W-1:0] r_late_limit;
    logic [TIME_W-1:0] r_timer_overhead;

    // Latched request.
    logic [1:0]        r_op;
    logic [SLOT_W-1:0] r_slot;
    logic [TIME_W-1:0] r_deadline;
    logic [CODE_W-1:0] r_code;
    logic [TIME_W-1:0] r_now;

    // Sequencer.
    t_state    r_state;
    t_state    n_state;
    t_cell_cmd w_cmd;
    t_cell_ctl w_ctl;

    // Output register.
    logic        r_out_valid;
    logic        r_out_kind;
    logic [43:0] r_out_data;
    logic        r_out_last;
    logic        w_out_free;
    logic        w_out_load;
    logic        n_out_kind;
    logic [43:0] n_out_data;
    logic        n_out_last;

    // Chain wiring.
    t_entry w_entry [NUM_SLOTS];
    logic   w_rm    [NUM_SLOTS+1];
    logic   w_pass  [NUM_SLOTS+1];

    logic w_slot_ok;
    logic w_expired;
    logic w_accept;

    assign o_cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_late_limit     <= 16'd32767;
            r_timer_overhead <= 16'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LATE_LIMIT:     r_late_limit     <= i_cfg_data;
                CFG_TIMER_OVERHEAD: r_timer_overhead <= i_cfg_data;
                default:            r_late_limit     <= r_late_limit;
            endcase
        end
    end

    // Request capture; the overhead is taken from the deadline here.
    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= s_axis_tuser;
            r_slot     <= s_axis_tdata[2:0];
            r_deadline <= s_axis_tdata[18:3] - r_timer_overhead;
            r_code     <= s_axis_tdata[26:19];
            r_now      <= s_axis_tdata[42:27];
        end
    end

    assign w_slot_ok = (int'(r_slot) < NUM_SLOTS);
    assign w_expired = w_entry[0].valid && (t_dist(w_entry[0].deadline, r_now) > r_late_limit);
    assign w_out_free = !r_out_valid || m_axis_tready;

    // Broadcast bundle: command, key, current count and the new entry.
    assign w_ctl = {w_cmd, r_slot, r_now, 1'b1, r_slot, r_deadline, r_code};

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, cell command and result loading.
    always_comb begin
        n_state       = r_state;
        w_cmd         = CMD_HOLD;
        s_axis_tready = 1'b0;
        w_out_load    = 1'b0;
        n_out_kind    = KIND_CLOSE;
        n_out_data    = '0;
        n_out_last    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = ST_REMOVE;
                end
            end
            ST_REMOVE: begin
                if (w_slot_ok && (r_op == OP_SCHEDULE || r_op == OP_CANCEL)) begin
                    w_cmd = CMD_REMOVE;
                end
                if (w_slot_ok && r_op == OP_SCHEDULE) begin
                    n_state = ST_INSERT;
                end else if (r_op == OP_TICK) begin
                    n_state = ST_CHECK;
                end else begin
                    n_state = ST_CLOSE;
                end
            end
            ST_INSERT: begin
                w_cmd = CMD_INSERT;
                // The new entry lands at the head when the first cell is not ahead of it.
                n_state = w_pass[1] ? ST_CLOSE : ST_CHECK;
            end
            ST_CHECK: begin
                if (w_expired) begin
                    if (w_out_free) begin
                        w_cmd      = CMD_POP;
                        w_out_load = 1'b1;
                        n_out_kind = KIND_FIRED;
                        n_out_data = {17'd0, w_entry[0].deadline, w_entry[0].code,
                                      w_entry[0].slot};
                    end
                end else begin
                    n_state = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_out_kind = KIND_CLOSE;
                    n_out_last = 1'b1;
                    if (w_entry[0].valid) begin
                        n_out_data = {1'b1, w_entry[0].deadline, 27'd0};
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_kind <= n_out_kind;
            r_out_data <= n_out_data;
            r_out_last <= n_out_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_data};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    // Chain of cells; cell zero is the queue head.
    assign w_rm[0]   = 1'b0;
    assign w_pass[0] = 1'b1;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_left
            assign w_left = w_entry[g-1];
        end

        if (g == NUM_SLOTS - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_right
            assign w_right = w_entry[g+1];
        end

        stq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_rm    (w_rm[g]),
            .i_pass  (w_pass[g]),
            .o_entry (w_entry[g]),
            .o_rm    (w_rm[g+1]),
            .o_pass  (w_pass[g+1])
        );
    end

endmodule

### hw/rtl/stq_checker.sv
// ----------------------------------------------------------------------------
// Sorted timer queue checker
// Port level assertions on the request and result streams, bound to the top level.
// ----------------------------------------------------------------------------
module stq_checker
    import stq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Only the closing status ends a request.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_CLOSE)))
        else $error("last flag does not match result kind");

    // A fired result carries no compare status; a closing one no fired fields.
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == KIND_CLOSE) ? (m_axis_tdata[26:0] == 27'd0)
                                                       : (m_axis_tdata[43:27] == 17'd0))
        else $error("unused result fields not zero");

    // A new request is not taken while a request is still producing results.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted before previous one finished");

endmodule

bind sorted_software_timer_queue_top stq_checker u_stq_checker (.*);

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted timer queue testbench
// Drives schedule, cancel and tick requests into the timer queue, predicts the
// fired timers and the closing compare status of each request with a local
// model of the ordered queue, and checks every result field by field.
// ----------------------------------------------------------------------------
module testbench
    import stq_pkg::*;
();

    // Opcode that the block has no use for.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int QUEUE_DEPTH = STQ_NUM_SLOTS;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [1:0]  op;
        logic [2:0]  slot;
        logic [15:0] when;
        logic [7:0]  what;
        logic [15:0] now;
    } t_request;

    typedef struct {
        logic        kind;
        logic [2:0]  slot;
        logic [7:0]  code;
        logic [15:0] deadline;
        logic [15:0] cmp_value;
        logic        cmp_enable;
        logic        last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // Local copy of the ordered timer queue and its registers.
    logic [15:0] model_deadline [QUEUE_DEPTH];
    logic [2:0]  model_slot [QUEUE_DEPTH];
    logic [7:0]  model_code [QUEUE_DEPTH];
    int          model_length = 0;
    logic [15:0] model_late_limit = 16'd32767;
    logic [15:0] model_overhead = 16'd0;

    t_result     pending_results [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          rx_hold_cycles = 0;
    bit          rx_steady = 1'b0;
    bit          tx_steady = 1'b0;
    logic [15:0] timeline_now = 16'd0;

    sorted_software_timer_queue_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // Wrapped distance of a deadline ahead of the current count.
    function automatic logic [15:0] ticks_ahead(input logic [15:0] deadline,
                                                input logic [15:0] now);
        ticks_ahead = deadline - now;
    endfunction

    // Take every entry of one slot out of the queue, closing the gap.
    function automatic void drop_slot(input logic [2:0] slot);
        int i;
        i = 0;
        while (i < model_length) begin
            if (model_slot[i] == slot) begin
                for (int j = i; j + 1 < model_length; j++) begin
                    model_slot[j]     = model_slot[j + 1];
                    model_deadline[j] = model_deadline[j + 1];
                    model_code[j]     = model_code[j + 1];
                end
                model_length--;
            end else begin
                i++;
            end
        end
    endfunction

    // Apply one accepted request to the queue and store the results it causes.
    function automatic void advance_timer_queue(input t_request r);
        logic [15:0] dl;
        int          pos;
        bit          check;
        t_result     res;
        check = 1'b0;
        if (r.op == OP_SCHEDULE) begin
            dl = r.when - model_overhead;
            drop_slot(r.slot);
            pos = 0;
            while (pos < model_length &&
                   ticks_ahead(model_deadline[pos], r.now) < ticks_ahead(dl, r.now))
                pos++;
            for (int j = model_length; j > pos; j--) begin
                model_slot[j]     = model_slot[j - 1];
                model_deadline[j] = model_deadline[j - 1];
                model_code[j]     = model_code[j - 1];
            end
            model_slot[pos]     = r.slot;
            model_deadline[pos] = dl;
            model_code[pos]     = r.what;
            model_length++;
            check = (pos == 0);
        end else if (r.op == OP_CANCEL) begin
            drop_slot(r.slot);
        end else if (r.op == OP_TICK) begin
            check = 1'b1;
        end

        // Pop every head entry that has already passed.
        if (check) begin
            while (model_length > 0 &&
                   ticks_ahead(model_deadline[0], r.now) > model_late_limit) begin
                res.kind       = KIND_FIRED;
                res.slot       = model_slot[0];
                res.code       = model_code[0];
                res.deadline   = model_deadline[0];
                res.cmp_value  = '0;
                res.cmp_enable = 1'b0;
                res.last       = 1'b0;
                pending_results.push_back(res);
                drop_slot(model_slot[0]);
            end
        end

        // The closing status always follows.
        res.kind       = KIND_CLOSE;
        res.slot       = '0;
        res.code       = '0;
        res.deadline   = '0;
        res.cmp_value  = (model_length > 0) ? model_deadline[0] : 16'd0;
        res.cmp_enable = (model_length > 0);
        res.last       = 1'b1;
        pending_results.push_back(res);
    endfunction

    function automatic t_request make_request(input logic [1:0] op, input logic [2:0] slot,
                                              input logic [15:0] when, input logic [7:0] what,
                                              input logic [15:0] now);
        t_request r;
        r.op   = op;
        r.slot = slot;
        r.when = when;
        r.what = what;
        r.now  = now;
        return r;
    endfunction

    // Mostly well-formed traffic on a forward running count, with some noise.
    function automatic t_request next_request();
        t_request r;
        int       pick;
        pick = $urandom_range(0, 99);
        timeline_now = timeline_now + 16'($urandom_range(0, 300));
        r = make_request(OP_TICK, 3'($urandom), 16'($urandom), 8'($urandom), timeline_now);
        if (pick < 45) begin
            r.op = OP_SCHEDULE;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                r.when = timeline_now + model_overhead + 16'($urandom_range(0, 2000));
            else if (pick < 85 || model_length == 0)
                r.when = 16'($urandom);
            else
                // Same deadline as a queued entry, so the new one goes ahead.
                r.when = model_deadline[$urandom_range(0, model_length - 1)] + model_overhead;
        end else if (pick < 65) begin
            if (model_length > 0 && $urandom_range(0, 2) == 0) begin
                timeline_now = model_deadline[0] + 16'($urandom_range(0, 400));
                r.now = timeline_now;
            end
        end else if (pick < 80) begin
            r.op = OP_CANCEL;
            if (model_length > 0 && $urandom_range(0, 4) < 3)
                r.slot = model_slot[$urandom_range(0, model_length - 1)];
        end else begin
            r.op  = 2'($urandom_range(0, 3));
            r.now = 16'($urandom);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        error_count++;
        if (error_count <= 40)
            $display("mismatch in %s at %0t: got %h, expected %h", field, $realtime, got, want);
    endtask

    // Offer one request, with an occasional gap ahead of it, and wait for it.
    task automatic send_request(input t_request r);
        if (!tx_steady && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tdata  = {5'd0, r.now, r.what, r.when, r.slot};
        s_axis_tuser  = r.op;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_timer_queue(r);
    endtask

    task automatic park_sender();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_results_done();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_register(input logic index, input logic [15:0] value);
        park_sender();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_index = index;
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_LATE_LIMIT)
            model_late_limit = value;
        else
            model_overhead = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Empty queue tick and the unused opcode.
    task automatic test_empty_queue();
        send_request(make_request(OP_TICK, 3'd0, 16'd0, 8'd0, 16'd0));
        send_request(make_request(OP_UNUSED, 3'd7, 16'hFFFF, 8'hFF, 16'hFFFF));
    endtask

    // Fill every slot, with a tie on distance and a deadline at the far end.
    task automatic test_fill_and_order();
        for (int s = 0; s < QUEUE_DEPTH; s++) begin
            send_request(make_request(OP_SCHEDULE, 3'(s),
                                      (s == 7) ? 16'hFFFF : (s == 3) ? 16'd120 : 16'(100 + 10 * s),
                                      (s == 0) ? 8'h00 : (s == 7) ? 8'hFF : 8'($urandom),
                                      16'd0));
        end
        // Reschedule a queued slot to the head.
        send_request(make_request(OP_SCHEDULE, 3'd5, 16'd50, 8'h5A, 16'd0));
    endtask

    // Cancel of the head far past its deadline, then of a slot not queued.
    task automatic test_cancel();
        send_request(make_request(OP_CANCEL, 3'd5, 16'd0, 8'd0, 16'h9000));
        send_request(make_request(OP_CANCEL, 3'd5, 16'd0, 8'd0, 16'h9000));
        send_request(make_request(OP_SCHEDULE, 3'd5, 16'd150, 8'hA5, 16'd0));
    endtask

    // A full queue expires on one tick; a passed deadline expires at once.
    task automatic test_expiry();
        send_request(make_request(OP_SCHEDULE, 3'd0, 16'hFFFF, 8'h3C, 16'hFFFF));
        send_request(make_request(OP_TICK, 3'd0, 16'd0, 8'd0, 16'd200));
        send_request(make_request(OP_SCHEDULE, 3'd4, 16'd10, 8'h77, 16'd500));
    endtask

    // Smallest expiry window with the largest overhead.
    task automatic test_register_extremes();
        write_register(CFG_LATE_LIMIT, 16'd0);
        write_register(CFG_TIMER_OVERHEAD, 16'hFFFF);
        send_request(make_request(OP_SCHEDULE, 3'd1, 16'd5, 8'h11, 16'd6));
        send_request(make_request(OP_TICK, 3'd0, 16'd0, 8'd0, 16'd7));
        park_sender();
    endtask

    task automatic test_random_phase(input int count, input logic [15:0] late_limit,
                                     input logic [15:0] overhead, input bit steady);
        write_register(CFG_LATE_LIMIT, late_limit);
        write_register(CFG_TIMER_OVERHEAD, overhead);
        tx_steady = steady;
        rx_steady = steady;
        for (int n = 0; n < count; n++) begin
            send_request(next_request());
            // Now and then let the queue drain before going on.
            if (!steady && $urandom_range(0, 39) == 0) begin
                park_sender();
                wait_results_done();
            end
        end
        park_sender();
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        write_register(CFG_LATE_LIMIT, 16'd1500);
        write_register(CFG_TIMER_OVERHEAD, 16'd100);
        tx_steady = 1'b1;
        rx_hold_cycles = 200;
        for (int n = 0; n < 24; n++)
            send_request(next_request());
        park_sender();
        wait_results_done();
        tx_steady = 1'b0;
    endtask

    // Receiver: random stall bursts, and one long hold when asked for.
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready = 1'b0;
                repeat (rx_hold_cycles) @(negedge i_clk);
                rx_hold_cycles = 0;
            end else if (!rx_steady && $urandom_range(0, 7) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    // Compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind       = m_axis_tuser;
            got.slot       = m_axis_tdata[2:0];
            got.code       = m_axis_tdata[10:3];
            got.deadline   = m_axis_tdata[26:11];
            got.cmp_value  = m_axis_tdata[42:27];
            got.cmp_enable = m_axis_tdata[43];
            got.last       = m_axis_tlast;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected", got.cmp_value, 16'd0);
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("kind", 16'(got.kind), 16'(want.kind));
                if (got.slot !== want.slot)
                    report_mismatch("fired_slot", 16'(got.slot), 16'(want.slot));
                if (got.code !== want.code)
                    report_mismatch("fired_code", 16'(got.code), 16'(want.code));
                if (got.deadline !== want.deadline)
                    report_mismatch("fired_deadline", got.deadline, want.deadline);
                if (got.cmp_value !== want.cmp_value)
                    report_mismatch("compare_value", got.cmp_value, want.cmp_value);
                if (got.cmp_enable !== want.cmp_enable)
                    report_mismatch("compare_enable", 16'(got.cmp_enable),
                                    16'(want.cmp_enable));
                if (got.last !== want.last)
                    report_mismatch("last", 16'(got.last), 16'(want.last));
            end
        end
    end

    // Watchdog on cycles in which no request moves on any channel.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_queue();
        test_fill_and_order();
        test_cancel();
        test_expiry();
        test_register_extremes();
        test_random_phase(70, 16'd32767, 16'd0, 1'b0);
        test_random_phase(40, 16'd0, 16'd1, 1'b0);
        test_random_phase(40, 16'hFFFF, 16'hFFFF, 1'b0);
        test_random_phase(50, 16'($urandom), 16'($urandom), 1'b0);
        test_output_backpressure();
        test_random_phase(60, 16'd800, 16'd30, 1'b1);

        wait_results_done();
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
